// ===== rtl/core/bpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for pressure compensation
// Field widths, fixed-point shift amounts, calibration register map and the
// stage-enable vector that runs the datapath pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int RAW_W      = 24;  // raw conversion results D1, D2
  localparam int CAL_W      = 16;  // calibration words C1..C6
  localparam int DT_W       = 25;  // dT = D2 - C5*256
  localparam int PROD_W     = 41;  // dT * Cx
  localparam int TEMP_W     = 19;  // TEMP, 0.01 degC
  localparam int OFF_W      = 35;  // OFF
  localparam int SENS_W     = 34;  // SENS
  localparam int SPLIT_W    = 17;  // SENS is cut into two 17-bit halves
  localparam int PART_W     = 41;  // D1 * half of SENS
  localparam int FULL_W     = 58;  // D1 * SENS
  localparam int DIFF_W     = 38;  // D1*SENS/2^21 - OFF
  localparam int PRES_W     = 23;  // P, 0.01 mbar

  localparam int T_SHIFT    = 23;
  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SHIFT = 8;
  localparam int P_SHIFT    = 21;
  localparam int OUT_SHIFT  = 15;

  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

  localparam int NUM_STAGES = 7;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // One load enable per pipeline stage, stage 0 at bit 0.
  typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage : bpc_pkg
`default_nettype wire

// ===== rtl/core/barometric_pressure_compensation.sv =====
`default_nettype none
// Pipeline: 7 stages, from input capture (0) to the output register (6).
// Throughput: 1 item per cycle while the output is not stalled; every stage
//   has its own valid bit, so bubbles fill in behind a stalled output and the
//   input only stalls when the whole pipeline is full.
// Reset: rst_n (sync, active low) clears the valid bits and sets all six
//   calibration words to zero. Datapath registers are not reset.
// ----------------------------------------------------------------------------
// barometric_pressure_compensation: first-order pressure/temperature compensation
// Takes raw pressure and temperature conversions, returns temperature in
// 0.01 degC and pressure in 0.01 mbar from six calibration words.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  wire  logic                     clk,
  input  wire  logic                     rst_n,
  // input channel
  input  wire  logic                     in_valid,
  output logic                           in_stall,
  input  wire  logic [RAW_W-1:0]         in_pressure_raw,
  input  wire  logic [RAW_W-1:0]         in_temperature_raw,
  // result channel
  output logic                           out_valid,
  input  wire  logic                     out_stall,
  output logic signed [TEMP_W-1:0]       out_temperature_centi,
  output logic signed [PRES_W-1:0]       out_pressure_centi,
  // calibration write port
  input  wire  logic                     cfg_wr_en,
  input  wire  logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire  logic [CAL_W-1:0]         cfg_wdata
);

  // Pipeline map:
  //   0  dT = D2 - C5*256                  (capture of the input item)
  //   1  dT*C6, dT*C4, dT*C3               (three 25x17 multipliers)
  //   2  TEMP, OFF, SENS                   (truncating scale + add)
  //   3  D1*SENS[16:0], D1*SENS[33:17]     (two 24x17 multipliers)
  //   4  D1*SENS                           (join partial products)
  //   5  D1*SENS/2^21 - OFF
  //   6  /2^15, output register

  cal_t      cal_r;
  stage_en_t vld_r;
  stage_en_t vld_nxt;
  stage_en_t stage_en;

  logic        [RAW_W-1:0]  d1_f;
  logic signed [TEMP_W-1:0] temp_f;
  logic signed [OFF_W-1:0]  off_f;
  logic signed [SENS_W-1:0] sens_f;

  // Calibration words; user must write only with no item in flight, so stages
  // read them directly; not enforced by the block. Indexes above C6 are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_C1:  cal_r.c1 <= cfg_wdata;
        REG_C2:  cal_r.c2 <= cfg_wdata;
        REG_C3:  cal_r.c3 <= cfg_wdata;
        REG_C4:  cal_r.c4 <= cfg_wdata;
        REG_C5:  cal_r.c5 <= cfg_wdata;
        REG_C6:  cal_r.c6 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    stage_en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES-2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = stage_en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = stage_en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !stage_en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  bpc_front u_front (
    .clk      (clk),
    .stage_en (stage_en),
    .cal      (cal_r),
    .d1_in    (in_pressure_raw),
    .d2_in    (in_temperature_raw),
    .d1_out   (d1_f),
    .temp_out (temp_f),
    .off_out  (off_f),
    .sens_out (sens_f)
  );

  bpc_pres u_pres (
    .clk      (clk),
    .stage_en (stage_en),
    .d1_in    (d1_f),
    .temp_in  (temp_f),
    .off_in   (off_f),
    .sens_in  (sens_f),
    .temp_out (out_temperature_centi),
    .pres_out (out_pressure_centi)
  );

endmodule : barometric_pressure_compensation
`default_nettype wire

// ===== rtl/core/bpc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_front: temperature, offset and sensitivity stages
// Stage 0 forms dT, stage 1 the three dT products, stage 2 the truncating
// scale and the sums that give TEMP, OFF and SENS.
// ----------------------------------------------------------------------------
module bpc_front
  import bpc_pkg::*;
(
  input  wire  logic                     clk,
  input  wire  stage_en_t                stage_en,
  input  wire  cal_t                     cal,
  input  wire  logic [RAW_W-1:0]         d1_in,
  input  wire  logic [RAW_W-1:0]         d2_in,
  output logic       [RAW_W-1:0]         d1_out,
  output logic signed [TEMP_W-1:0]       temp_out,
  output logic signed [OFF_W-1:0]        off_out,
  output logic signed [SENS_W-1:0]       sens_out
);

  localparam logic [PROD_W-1:0] T_RND   = (PROD_W'(1) << T_SHIFT) - PROD_W'(1);
  localparam logic [PROD_W-1:0] OFF_RND = (PROD_W'(1) << OFF_SHIFT) - PROD_W'(1);
  localparam logic [PROD_W-1:0] S_RND   = (PROD_W'(1) << SENS_SHIFT) - PROD_W'(1);

  // stage 0
  logic        [RAW_W-1:0]  d1_0_r;
  logic signed [DT_W-1:0]   dt_0_r;
  logic signed [DT_W-1:0]   dt_nxt;
  // stage 1
  logic        [RAW_W-1:0]  d1_1_r;
  logic signed [PROD_W-1:0] pt_1_r;
  logic signed [PROD_W-1:0] po_1_r;
  logic signed [PROD_W-1:0] ps_1_r;
  logic signed [PROD_W-1:0] pt_nxt;
  logic signed [PROD_W-1:0] po_nxt;
  logic signed [PROD_W-1:0] ps_nxt;
  // stage 2
  logic        [RAW_W-1:0]  d1_2_r;
  logic signed [TEMP_W-1:0] temp_2_r;
  logic signed [OFF_W-1:0]  off_2_r;
  logic signed [SENS_W-1:0] sens_2_r;
  logic signed [PROD_W-1:0] pt_adj;
  logic signed [PROD_W-1:0] po_adj;
  logic signed [PROD_W-1:0] ps_adj;
  logic signed [PROD_W-1:0] pt_sh;
  logic signed [PROD_W-1:0] po_sh;
  logic signed [PROD_W-1:0] ps_sh;
  logic signed [TEMP_W-1:0] temp_nxt;
  logic signed [OFF_W-1:0]  off_nxt;
  logic signed [SENS_W-1:0] sens_nxt;

  assign dt_nxt = $signed({1'b0, d2_in}) - $signed({1'b0, cal.c5, 8'd0});

  assign pt_nxt = dt_0_r * $signed({1'b0, cal.c6});
  assign po_nxt = dt_0_r * $signed({1'b0, cal.c4});
  assign ps_nxt = dt_0_r * $signed({1'b0, cal.c3});

  // Divide by 2^k toward zero: bias negative values by 2^k-1, then shift.
  assign pt_adj = pt_1_r + $signed(pt_1_r[PROD_W-1] ? T_RND : '0);
  assign po_adj = po_1_r + $signed(po_1_r[PROD_W-1] ? OFF_RND : '0);
  assign ps_adj = ps_1_r + $signed(ps_1_r[PROD_W-1] ? S_RND : '0);
  assign pt_sh  = pt_adj >>> T_SHIFT;
  assign po_sh  = po_adj >>> OFF_SHIFT;
  assign ps_sh  = ps_adj >>> SENS_SHIFT;

  assign temp_nxt = TEMP_BASE + TEMP_W'(pt_sh);
  assign off_nxt  = $signed({3'b0, cal.c2, 16'd0}) + OFF_W'(po_sh);
  assign sens_nxt = $signed({3'b0, cal.c1, 15'd0}) + SENS_W'(ps_sh);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      d1_0_r <= d1_in;
      dt_0_r <= dt_nxt;
    end
    if (stage_en[1]) begin
      d1_1_r <= d1_0_r;
      pt_1_r <= pt_nxt;
      po_1_r <= po_nxt;
      ps_1_r <= ps_nxt;
    end
    if (stage_en[2]) begin
      d1_2_r   <= d1_1_r;
      temp_2_r <= temp_nxt;
      off_2_r  <= off_nxt;
      sens_2_r <= sens_nxt;
    end
  end

  assign d1_out   = d1_2_r;
  assign temp_out = temp_2_r;
  assign off_out  = off_2_r;
  assign sens_out = sens_2_r;

endmodule : bpc_front
`default_nettype wire

// ===== rtl/core/bpc_pres.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pres: pressure stages
// Stage 3 multiplies D1 by both halves of SENS, stage 4 joins the partial
// products, stage 5 scales and subtracts OFF, stage 6 is the output register.
// ----------------------------------------------------------------------------
module bpc_pres
  import bpc_pkg::*;
(
  input  wire  logic                     clk,
  input  wire  stage_en_t                stage_en,
  input  wire  logic [RAW_W-1:0]         d1_in,
  input  wire  logic signed [TEMP_W-1:0] temp_in,
  input  wire  logic signed [OFF_W-1:0]  off_in,
  input  wire  logic signed [SENS_W-1:0] sens_in,
  output logic signed [TEMP_W-1:0]       temp_out,
  output logic signed [PRES_W-1:0]       pres_out
);

  localparam logic [FULL_W-1:0] P_RND   = (FULL_W'(1) << P_SHIFT) - FULL_W'(1);
  localparam logic [DIFF_W-1:0] OUT_RND = (DIFF_W'(1) << OUT_SHIFT) - DIFF_W'(1);

  // stage 3
  logic        [PART_W-1:0] pl_3_r;
  logic signed [PART_W-1:0] ph_3_r;
  logic signed [TEMP_W-1:0] temp_3_r;
  logic signed [OFF_W-1:0]  off_3_r;
  logic        [PART_W-1:0] pl_nxt;
  logic signed [PART_W-1:0] ph_nxt;
  // stage 4
  logic signed [FULL_W-1:0] full_4_r;
  logic signed [TEMP_W-1:0] temp_4_r;
  logic signed [OFF_W-1:0]  off_4_r;
  logic signed [FULL_W-1:0] full_nxt;
  // stage 5
  logic signed [DIFF_W-1:0] diff_5_r;
  logic signed [TEMP_W-1:0] temp_5_r;
  logic signed [FULL_W-1:0] full_adj;
  logic signed [FULL_W-1:0] full_sh;
  logic signed [DIFF_W-1:0] diff_nxt;
  // stage 6
  logic signed [PRES_W-1:0] pres_6_r;
  logic signed [TEMP_W-1:0] temp_6_r;
  logic signed [DIFF_W-1:0] diff_adj;
  logic signed [DIFF_W-1:0] diff_sh;

  // Low half of SENS is unsigned, high half carries the sign.
  assign pl_nxt = PART_W'(d1_in) * PART_W'(sens_in[SPLIT_W-1:0]);
  assign ph_nxt = $signed({1'b0, d1_in}) * $signed(sens_in[SENS_W-1:SPLIT_W]);

  assign full_nxt = (FULL_W'(ph_3_r) <<< SPLIT_W) + $signed(FULL_W'(pl_3_r));

  assign full_adj = full_4_r + $signed(full_4_r[FULL_W-1] ? P_RND : '0);
  assign full_sh  = full_adj >>> P_SHIFT;
  assign diff_nxt = DIFF_W'(full_sh) - DIFF_W'(off_4_r);

  assign diff_adj = diff_5_r + $signed(diff_5_r[DIFF_W-1] ? OUT_RND : '0);
  assign diff_sh  = diff_adj >>> OUT_SHIFT;

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      pl_3_r   <= pl_nxt;
      ph_3_r   <= ph_nxt;
      temp_3_r <= temp_in;
      off_3_r  <= off_in;
    end
    if (stage_en[4]) begin
      full_4_r <= full_nxt;
      temp_4_r <= temp_3_r;
      off_4_r  <= off_3_r;
    end
    if (stage_en[5]) begin
      diff_5_r <= diff_nxt;
      temp_5_r <= temp_4_r;
    end
    if (stage_en[6]) begin
      pres_6_r <= PRES_W'(diff_sh);
      temp_6_r <= temp_5_r;
    end
  end

  assign temp_out = temp_6_r;
  assign pres_out = pres_6_r;

endmodule : bpc_pres
`default_nettype wire
